// File: sv/round_robin_ready_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Round-robin ready queue assertion macros
// Concurrent check macros used by the RTL; empty when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_READY_QUEUE_TOP_ASSERT_SVH
`define ROUND_ROBIN_READY_QUEUE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define RRQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrq check failed");

// Next-cycle implication.
`define RRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrq check failed");

`else

`define RRQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RRQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/rrq_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin ready queue package
// Sizes, operation codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package rrq_pkg;

   localparam int MAX_TASKS = 64;
   localparam int TASK_W    = 6;
   localparam int OP_W      = 2;
   localparam int SLOT_W    = $clog2(MAX_TASKS);

   typedef logic [TASK_W-1:0] task_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [OP_W-1:0]   op_type;

   localparam op_type OP_ADD    = 2'd0;
   localparam op_type OP_REMOVE = 2'd1;
   localparam op_type OP_TICK   = 2'd2;

endpackage

`default_nettype wire

// File: sv/rrq_if.sv
// ----------------------------------------------------------------------------
// Round-robin ready queue channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrq_req_if;
   logic              valid;
   logic              ready;
   rrq_pkg::op_type   op;
   rrq_pkg::task_type task_id;

   modport source (output valid, op, task_id, input ready);
   modport sink   (input valid, op, task_id, output ready);
endinterface

interface rrq_rsp_if;
   logic              valid;
   logic              ready;
   rrq_pkg::task_type head_task;
   logic              head_valid;
   rrq_pkg::task_type running_task_out;
   logic              running_valid;
   logic              switched;
   logic              status;

   modport source (output valid, head_task, head_valid, running_task_out,
                   running_valid, switched, status, input ready);
   modport sink   (input valid, head_task, head_valid, running_task_out,
                   running_valid, switched, status, output ready);
endinterface

`default_nettype wire

// File: sv/round_robin_ready_queue_top.sv
// ----------------------------------------------------------------------------
// Round-robin ready queue
// Doubly linked ready queue of task slots with add, remove and tick requests.
// ----------------------------------------------------------------------------
// In the cycle a request is accepted the block issues reads of the next and
// previous link RAMs; in the ST_EXEC state it then uses the read data to
// update head, tail, queued marks and running task, and on commit it
// writes at most one entry back into each link RAM. The link RAM reads are
// registered, and no new request is taken until the current one has committed. The result
// is held in an output register, so a result waiting on rsp ready does not
// stop the next request from being accepted; only the commit waits for the
// register to free up. Link entries are undefined after reset and are only
// used for queued slots; queued marks are flip-flops cleared by reset, so the
// block is ready right out of reset. Duplicate adds, removes of absent tasks,
// adds and removes of out-of-range slots and unused op codes change nothing and report status 1.
// ----------------------------------------------------------------------------
`default_nettype none
`include "round_robin_ready_queue_top_assert.svh"

module round_robin_ready_queue_top (
   input  wire logic  clock,
   input  wire logic  reset,
   rrq_req_if.sink    req_port,
   rrq_rsp_if.source  rsp_port
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   // control state
   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // captured request
   rrq_pkg::op_type   op_ff;
   rrq_pkg::slot_type id_ff;
   logic              id_ok_ff;

   // queue state
   rrq_pkg::slot_type          head_ff, head_in;
   rrq_pkg::slot_type          tail_ff, tail_in;
   logic                       nonempty_ff, nonempty_in;
   rrq_pkg::slot_type          run_ff, run_in;
   logic                       run_known_ff, run_known_in;
   logic [rrq_pkg::MAX_TASKS-1:0] mark_ff, mark_in;

   // result register
   rrq_pkg::task_type out_head_ff, out_run_ff;
   logic              out_head_valid_ff, out_run_valid_ff, out_sw_ff, out_status_ff;
   logic              sw, status;

   // link RAM ports
   logic              accept, commit;
   rrq_pkg::slot_type req_slot;
   logic              req_ok;
   rrq_pkg::slot_type next_rd_addr, next_rd, prev_rd;
   logic              next_wr_en, prev_wr_en;
   rrq_pkg::slot_type next_wr_addr, next_wr_data, prev_wr_addr, prev_wr_data;
   logic              is_queued, is_head, is_tail;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign accept         = req_port.valid && req_port.ready;
   // commit only when the result register is free or being drained
   assign commit         = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_port.ready);

   assign req_slot = rrq_pkg::SLOT_W'(req_port.task_id);
   assign req_ok   = int'(req_port.task_id) < rrq_pkg::MAX_TASKS;

   // A tick needs the successor of the head; add/remove need the task's links.
   assign next_rd_addr = (req_port.op == rrq_pkg::OP_TICK) ? head_ff : req_slot;

   rrq_link_ram #(.DEPTH(rrq_pkg::MAX_TASKS), .WIDTH(rrq_pkg::SLOT_W)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr_en),
      .wr_addr (next_wr_addr),
      .wr_data (next_wr_data),
      .rd_en   (accept),
      .rd_addr (next_rd_addr),
      .rd_data (next_rd)
   );

   rrq_link_ram #(.DEPTH(rrq_pkg::MAX_TASKS), .WIDTH(rrq_pkg::SLOT_W)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_wr_en),
      .wr_addr (prev_wr_addr),
      .wr_data (prev_wr_data),
      .rd_en   (accept),
      .rd_addr (req_slot),
      .rd_data (prev_rd)
   );

   // Writes happen only in the commit cycle and reads only on accept, which
   // needs ST_IDLE and so comes after the commit, so no forwarding path is needed.

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_port.op;
         id_ff    <= req_slot;
         id_ok_ff <= req_ok;
      end
   end

   assign is_queued = id_ok_ff && mark_ff[id_ff];
   assign is_head   = (id_ff == head_ff);
   assign is_tail   = (id_ff == tail_ff);

   // Read-modify-write of the queue. Tail's next and head's prev are never
   // followed, so they are left stale instead of being cleared.
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      nonempty_in  = nonempty_ff;
      run_in       = run_ff;
      run_known_in = run_known_ff;
      mark_in      = mark_ff;
      sw           = 1'b0;
      status       = 1'b0;
      next_wr_en   = 1'b0;
      next_wr_addr = tail_ff;
      next_wr_data = id_ff;
      prev_wr_en   = 1'b0;
      prev_wr_addr = id_ff;
      prev_wr_data = tail_ff;

      unique case (op_ff)
         rrq_pkg::OP_ADD: begin
            if (!id_ok_ff || is_queued) begin
               status = 1'b1;
            end else begin
               mark_in[id_ff] = 1'b1;
               tail_in        = id_ff;
               if (!nonempty_ff) begin
                  head_in     = id_ff;
                  nonempty_in = 1'b1;
               end else begin
                  // link behind the old tail
                  next_wr_en = 1'b1;
                  prev_wr_en = 1'b1;
               end
            end
         end
         rrq_pkg::OP_REMOVE: begin
            if (!is_queued || !nonempty_ff) begin
               status = 1'b1;
            end else begin
               mark_in[id_ff] = 1'b0;
               priority if (is_head && is_tail) begin
                  nonempty_in = 1'b0;
                  head_in     = '0;
                  tail_in     = '0;
               end else if (is_head) begin
                  head_in = next_rd;
               end else if (is_tail) begin
                  tail_in = prev_rd;
               end else begin
                  // splice neighbors together
                  next_wr_en   = 1'b1;
                  next_wr_addr = prev_rd;
                  next_wr_data = next_rd;
                  prev_wr_en   = 1'b1;
                  prev_wr_addr = next_rd;
                  prev_wr_data = prev_rd;
               end
            end
         end
         rrq_pkg::OP_TICK: begin
            if (nonempty_ff) begin
               if (head_ff != tail_ff) begin
                  // rotate head to tail
                  head_in      = next_rd;
                  tail_in      = head_ff;
                  next_wr_en   = 1'b1;
                  next_wr_addr = tail_ff;
                  next_wr_data = head_ff;
                  prev_wr_en   = 1'b1;
                  prev_wr_addr = head_ff;
                  prev_wr_data = tail_ff;
               end
               if (!run_known_ff || (run_ff != head_in)) begin
                  run_in       = head_in;
                  run_known_in = 1'b1;
                  sw           = 1'b1;
               end
            end
         end
         default: begin
            status = 1'b1;
         end
      endcase

      if (!commit) begin
         next_wr_en = 1'b0;
         prev_wr_en = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         nonempty_ff  <= 1'b0;
         run_ff       <= '0;
         run_known_ff <= 1'b0;
         mark_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            nonempty_ff  <= nonempty_in;
            run_ff       <= run_in;
            run_known_ff <= run_known_in;
            mark_ff      <= mark_in;
         end
      end
   end

   // result payload, loaded with the commit
   always_ff @(posedge clock) begin
      if (commit) begin
         out_head_ff       <= nonempty_in ? rrq_pkg::TASK_W'(head_in) : '0;
         out_head_valid_ff <= nonempty_in;
         out_run_ff        <= rrq_pkg::TASK_W'(run_in);
         out_run_valid_ff  <= run_known_in;
         out_sw_ff         <= sw;
         out_status_ff     <= status;
      end
   end

   assign rsp_port.valid            = rsp_valid_ff;
   assign rsp_port.head_task        = out_head_ff;
   assign rsp_port.head_valid       = out_head_valid_ff;
   assign rsp_port.running_task_out = out_run_ff;
   assign rsp_port.running_valid    = out_run_valid_ff;
   assign rsp_port.switched         = out_sw_ff;
   assign rsp_port.status           = out_status_ff;

   // checks
   `RRQ_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == ST_EXEC && !req_port.ready)
   `RRQ_ASSERT_IMPL(a_empty_zero, clock, reset, !nonempty_ff, head_ff == '0 && tail_ff == '0)
   `RRQ_ASSERT_IMPL(a_ends_queued, clock, reset, nonempty_ff, mark_ff[head_ff] && mark_ff[tail_ff])
   `RRQ_ASSERT_NEXT(a_run_sticky, clock, reset, run_known_ff, run_known_ff)

endmodule

`default_nettype wire

// File: sv/rrq_link_ram.sv
// ----------------------------------------------------------------------------
// Link RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rrq_link_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 6
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
